// File: src/wbct_pkg.sv
package wbct_pkg;

  // Field widths
  localparam int unsigned DUR_W   = 23;
  localparam int unsigned MIN_W   = 7;
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned IDX_W   = 1;

  // Whole seconds of a 23-bit millisecond count stay below 8389.
  localparam int unsigned SECS_W = 14;
  // Whole minutes of that count stay below 140.
  localparam int unsigned MINS_W = 8;

  // Phase codes as they appear on the result channel.
  localparam logic [PHASE_W-1:0] PHASE_IDLE   = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_WORK   = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_BREAK  = 2'd2;
  localparam logic [PHASE_W-1:0] PHASE_PAUSED = 2'd3;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_WORK_DUR  = 1'b0;
  localparam logic [IDX_W-1:0] REG_BREAK_DUR = 1'b1;

  // Reset values of the duration registers.
  localparam logic [DUR_W-1:0] WORK_DUR_RST  = 23'd1500000;
  localparam logic [DUR_W-1:0] BREAK_DUR_RST = 23'd300000;

  // ms / 1000 is computed as (ms >> 3) / 125, and that as a multiply by
  // ceil(2^27 / 125) and a right shift by 27, exact for 20-bit operands.
  localparam int unsigned      MS_DIV_X_W  = DUR_W - 3;
  localparam int unsigned      MS_MUL_W    = 21;
  localparam int unsigned      MS_PROD_W   = MS_DIV_X_W + MS_MUL_W;
  localparam int unsigned      MS_SHIFT    = 27;
  localparam logic [MS_MUL_W-1:0] MS_MUL   = 21'd1073742;

  // secs / 60 is computed as (secs >> 2) / 15, and that as a multiply by
  // ceil(2^16 / 15) and a right shift by 16, exact for 12-bit operands.
  localparam int unsigned      SEC_DIV_X_W = SECS_W - 2;
  localparam int unsigned      SEC_MUL_W   = 13;
  localparam int unsigned      SEC_PROD_W  = SEC_DIV_X_W + SEC_MUL_W;
  localparam int unsigned      SEC_SHIFT   = 16;
  localparam logic [SEC_MUL_W-1:0] SEC_MUL = 13'd4370;

  localparam logic [MINS_W-1:0] MINUTE_WRAP = 8'd100;

  // Status that rides along with the time value through the display pipeline.
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               press_beep;
    logic               timeup_beep;
  } wbct_tag_t;

endpackage

// File: src/wbct_time_split.sv
module wbct_time_split
  import wbct_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DUR_W-1:0]  in_ms,
  input  wbct_tag_t         in_tag,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [MIN_W-1:0]  out_minutes,
  output logic [SEC_W-1:0]  out_seconds,
  output wbct_tag_t         out_tag
);

  // Stage 1: millisecond count. Stage 2: whole seconds.
  // Stage 3: seconds and minutes. Stage 4: display fields.
  logic              v1_r, v2_r, v3_r, v4_r;
  logic              rdy1, rdy2, rdy3, rdy4;
  logic [DUR_W-1:0]  ms_r;
  logic [SECS_W-1:0] secs2_r, secs3_r;
  logic [MINS_W-1:0] mins3_r;
  logic [MIN_W-1:0]  minutes_r;
  logic [SEC_W-1:0]  seconds_r;
  wbct_tag_t         tag1_r, tag2_r, tag3_r, tag4_r;

  logic [MS_PROD_W-1:0]  ms_prod;
  logic [SEC_PROD_W-1:0] sec_prod;
  logic [SECS_W-1:0]     mins_x60;
  logic [SECS_W-1:0]     sec_rem;
  logic [MINS_W-1:0]     mins_wrapped;

  // A stage takes new data when it is empty or its successor takes its data.
  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign ms_prod  = MS_PROD_W'(ms_r[DUR_W-1:3]) * MS_PROD_W'(MS_MUL);
  assign sec_prod = SEC_PROD_W'(secs2_r[SECS_W-1:2]) * SEC_PROD_W'(SEC_MUL);

  // minutes * 60 as minutes * 64 - minutes * 4
  assign mins_x60     = (SECS_W'(mins3_r) << 6) - (SECS_W'(mins3_r) << 2);
  assign sec_rem      = secs3_r - mins_x60;
  assign mins_wrapped = (mins3_r >= MINUTE_WRAP) ? (mins3_r - MINUTE_WRAP) : mins3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      ms_r   <= in_ms;
      tag1_r <= in_tag;
    end
    if (rdy2) begin
      secs2_r <= ms_prod[MS_SHIFT +: SECS_W];
      tag2_r  <= tag1_r;
    end
    if (rdy3) begin
      secs3_r <= secs2_r;
      mins3_r <= sec_prod[SEC_SHIFT +: MINS_W];
      tag3_r  <= tag2_r;
    end
    if (rdy4) begin
      minutes_r <= mins_wrapped[MIN_W-1:0];
      seconds_r <= sec_rem[SEC_W-1:0];
      tag4_r    <= tag3_r;
    end
  end

  assign out_valid   = v4_r;
  assign out_minutes = minutes_r;
  assign out_seconds = seconds_r;
  assign out_tag     = tag4_r;

endmodule

// File: src/work_break_countdown_timer.sv
// Pipeline: an accepted input transaction passes the millisecond, whole-seconds,
// seconds-and-minutes and display-field registers in turn before out_valid rises.
// Throughput: one transaction per cycle if out_ready is high; the four-stage display pipeline
// collapses bubbles, so in_ready stays high while any stage is free, even if out_ready is low.
// Reset (rst_n low at a rising edge, synchronous) empties the pipeline, puts the timer in
// idle with the work phase remembered, loads 1500000 ms and sets the durations to defaults.
module work_break_countdown_timer
  import wbct_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_start_level,
  input  logic               in_reset_level,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [MIN_W-1:0]   out_shown_minutes,
  output logic [SEC_W-1:0]   out_shown_seconds,
  output logic [PHASE_W-1:0] out_phase,
  output logic               out_press_beep,
  output logic               out_timeup_beep,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [DUR_W-1:0]   cfg_wdata
);

  // Timer state, one-hot encoded.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_WORK   = 4'b0010,
    ST_BREAK  = 4'b0100,
    ST_PAUSED = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [DUR_W-1:0]  remaining_r, remaining_nxt;
  logic              paused_brk_r, paused_brk_nxt;
  logic              prev_start_r;
  logic              prev_reset_r;
  logic [DUR_W-1:0]  work_dur_r;
  logic [DUR_W-1:0]  break_dur_r;

  logic              in_acc;
  logic              start_edge;
  logic              reset_edge;
  logic              press;
  logic              timeup;
  logic [DUR_W-1:0]  shown_ms;
  wbct_tag_t         tag_in;
  wbct_tag_t         tag_out;

  assign in_acc = in_valid && in_ready;

  // A press is a falling edge of the active-low button level between two ticks.
  // Both levels are tracked on every tick, whatever the current phase.
  assign start_edge = !in_start_level && prev_start_r;
  assign reset_edge = !in_reset_level && prev_reset_r;

  // Next-state logic for one tick. The shown time is the remaining time after
  // this tick, except on an expiry tick, where it reads zero while the counter
  // already holds the full duration of the next phase.
  always_comb begin
    state_nxt      = state_r;
    remaining_nxt  = remaining_r;
    paused_brk_nxt = paused_brk_r;
    press          = 1'b0;
    timeup         = 1'b0;
    shown_ms       = remaining_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start_edge) begin
          press         = 1'b1;
          state_nxt     = ST_WORK;
          remaining_nxt = work_dur_r;
        end
        shown_ms = remaining_nxt;
      end
      ST_WORK, ST_BREAK: begin
        if (remaining_r <= DUR_W'(1)) begin
          // Countdown expired: switch to the other phase with its full length.
          timeup   = 1'b1;
          shown_ms = '0;
          if (state_r == ST_WORK) begin
            state_nxt     = ST_BREAK;
            remaining_nxt = break_dur_r;
          end else begin
            state_nxt     = ST_WORK;
            remaining_nxt = work_dur_r;
          end
        end else begin
          remaining_nxt = remaining_r - DUR_W'(1);
          shown_ms      = remaining_nxt;
        end
        // A start press pauses whichever phase is current after this tick,
        // which is the new phase when the press lands on an expiry tick.
        if (start_edge) begin
          press          = 1'b1;
          paused_brk_nxt = (state_nxt == ST_BREAK);
          state_nxt      = ST_PAUSED;
        end
      end
      ST_PAUSED: begin
        // Reset is honored only here and wins over a simultaneous start press.
        if (reset_edge) begin
          press         = 1'b1;
          state_nxt     = ST_IDLE;
          remaining_nxt = work_dur_r;
        end else if (start_edge) begin
          press     = 1'b1;
          state_nxt = paused_brk_r ? ST_BREAK : ST_WORK;
        end
        // A reset press shows the freshly loaded work time.
        shown_ms = remaining_nxt;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Phase code reported with the result, taken from the state after this tick.
  always_comb begin
    tag_in.press_beep  = press;
    tag_in.timeup_beep = timeup;
    unique case (state_nxt)
      ST_IDLE:   tag_in.phase = PHASE_IDLE;
      ST_WORK:   tag_in.phase = PHASE_WORK;
      ST_BREAK:  tag_in.phase = PHASE_BREAK;
      ST_PAUSED: tag_in.phase = PHASE_PAUSED;
      default:   tag_in.phase = PHASE_IDLE;
    endcase
  end

  // Timer state advances once per accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      remaining_r  <= WORK_DUR_RST;
      paused_brk_r <= 1'b0;
      prev_start_r <= 1'b0;
      prev_reset_r <= 1'b0;
    end else if (in_acc) begin
      state_r      <= state_nxt;
      remaining_r  <= remaining_nxt;
      paused_brk_r <= paused_brk_nxt;
      prev_start_r <= in_start_level;
      prev_reset_r <= in_reset_level;
    end
  end

  // Duration registers. A new value takes effect at the next load of the
  // counter; a countdown already in progress keeps its value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_dur_r  <= WORK_DUR_RST;
      break_dur_r <= BREAK_DUR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WORK_DUR:  work_dur_r  <= cfg_wdata;
        REG_BREAK_DUR: break_dur_r <= cfg_wdata;
        default:       work_dur_r  <= work_dur_r;
      endcase
    end
  end

  // Splits the shown milliseconds into minutes modulo 100 and seconds.
  wbct_time_split u_time_split (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_ms       (shown_ms),
    .in_tag      (tag_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_minutes (out_shown_minutes),
    .out_seconds (out_shown_seconds),
    .out_tag     (tag_out)
  );

  assign out_phase       = tag_out.phase;
  assign out_press_beep  = tag_out.press_beep;
  assign out_timeup_beep = tag_out.timeup_beep;

  // Without an accepted transaction the timer does not move.
  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(state_r) && $stable(remaining_r) && $stable(paused_brk_r))
    else $error("timer state changed without an accepted transaction");

  // A running phase with time left counts down by exactly one per tick.
  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (state_r == ST_WORK || state_r == ST_BREAK) && remaining_r > DUR_W'(1)
    |=> remaining_r == $past(remaining_r) - DUR_W'(1))
    else $error("running countdown did not decrement by one");

  // Paused with no press: time and phase stay frozen.
  a_pause_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && state_r == ST_PAUSED && !start_edge && !reset_edge
    |=> state_r == ST_PAUSED && $stable(remaining_r))
    else $error("paused timer moved without a press");

  // An expiry result always shows zero time.
  a_timeup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_timeup_beep |-> out_shown_minutes == '0 && out_shown_seconds == '0)
    else $error("time-up result shows nonzero time");

  // Time-up only comes out of a running phase, so the phase is never idle.
  a_timeup_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_timeup_beep |-> out_phase != PHASE_IDLE)
    else $error("time-up result reports idle phase");

endmodule
